>>> rtl/core/spsg_pkg.sv
// Shared types, codes and constants of the stepper PD step generator.
package spsg_pkg;

	localparam int POSITION_BITS_DEF = 24;
	localparam int DELAY_BITS_DEF    = 32;

	localparam int MOVE_W  = 24;
	localparam int SPR_W   = 15;
	localparam int SPEED_W = 16;
	localparam int GAIN_W  = 16;
	localparam int DEN_W   = SPR_W + SPEED_W;
	localparam int NUM_W   = 32;
	localparam int DIV_CNT_W = $clog2(NUM_W);
	localparam int OUT_W   = 32;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_ABS  = 2'd1;
	localparam logic [1:0] OP_REL  = 2'd2;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;

	localparam logic [1:0] REG_SPR   = 2'd0;
	localparam logic [1:0] REG_SPEED = 2'd1;
	localparam logic [1:0] REG_KP    = 2'd2;
	localparam logic [1:0] REG_KD    = 2'd3;

	localparam logic [SPR_W-1:0]   SPR_RST   = 15'd200;
	localparam logic [SPEED_W-1:0] SPEED_RST = 16'd4096;
	localparam logic [GAIN_W-1:0]  KP_RST    = 16'd82;
	localparam logic [GAIN_W-1:0]  KD_RST    = 16'd2867;

	// 1e6 microseconds in Q.12
	localparam logic [NUM_W-1:0] DELAY_NUM = 32'd4096000000;
	localparam logic [SPEED_W-1:0] CTL_MIN = 16'd8192;
	localparam logic [SPEED_W-1:0] CTL_MAX = 16'd49152;

	typedef struct packed {
		logic latch_in;
		logic exec;
		logic plan_diff;
		logic mul1;
		logic mul2;
		logic sum;
		logic den;
		logic div_step;
		logic load_delay;
		logic load_out;
	} spsg_cmd_t;

	typedef struct packed {
		logic go_plan;
		logic go_den;
		logic diff_zero;
		logic div_done;
	} spsg_sts_t;

endpackage

>>> rtl/core/spsg_ctrl.sv
// Sequencing state machine of the stepper PD step generator.
module spsg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output spsg_pkg::spsg_cmd_t cmd,
	input  spsg_pkg::spsg_sts_t sts
);
	import spsg_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DECODE = 4'd1;
	localparam logic [3:0] ST_DIFF   = 4'd2;
	localparam logic [3:0] ST_MUL1   = 4'd3;
	localparam logic [3:0] ST_MUL2   = 4'd4;
	localparam logic [3:0] ST_SUM    = 4'd5;
	localparam logic [3:0] ST_DEN    = 4'd6;
	localparam logic [3:0] ST_DIV    = 4'd7;
	localparam logic [3:0] ST_LOAD   = 4'd8;
	localparam logic [3:0] ST_OUT    = 4'd9;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.latch_in = 1'b1;
					state_d      = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.exec = 1'b1;
				if (sts.go_plan)
					state_d = ST_DIFF;
				else if (sts.go_den)
					state_d = ST_DEN;
				else
					state_d = ST_OUT;
			end
			ST_DIFF: begin
				cmd.plan_diff = 1'b1;
				state_d = sts.diff_zero ? ST_OUT : ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_DEN;
			end
			ST_DEN: begin
				cmd.den = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done)
					state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load_delay = 1'b1;
				state_d        = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_DECODE)
		else $error("accepted transaction not decoded");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_tready))
		else $error("result overwritten before it was taken");
	a_div_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && !sts.div_done |=> state_q == ST_DIV)
		else $error("divider left early");
`endif

endmodule

>>> rtl/core/spsg_dp.sv
// Position, timing, PD arithmetic and serial delay divider.
module spsg_dp #(
	parameter int POSITION_BITS = spsg_pkg::POSITION_BITS_DEF,
	parameter int DELAY_BITS    = spsg_pkg::DELAY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spsg_pkg::spsg_cmd_t           cmd,
	output spsg_pkg::spsg_sts_t           sts,
	input  logic [1:0]                    in_op,
	input  logic [spsg_pkg::MOVE_W-1:0]   in_val,
	input  logic [spsg_pkg::SPR_W-1:0]    steps_per_rev,
	input  logic [spsg_pkg::SPEED_W-1:0]  const_speed_q12,
	input  logic [spsg_pkg::GAIN_W-1:0]   kp_q12,
	input  logic [spsg_pkg::GAIN_W-1:0]   kd_q12,
	output logic [spsg_pkg::OUT_W-1:0]    out_data
);
	import spsg_pkg::*;

	localparam int PB = POSITION_BITS;
	localparam int DB = DELAY_BITS;
	localparam int SW = PB + GAIN_W + 2;

	logic [1:0]        op_q;
	logic [MOVE_W-1:0] val_q;
	logic [PB-1:0]     position_q, goal_q, prev_err_q, err_q;
	logic [MOVE_W-1:0] steps_left_q;
	logic              pd_mode_q, direction_q;
	logic [1:0]        phase_q;
	logic [DB-1:0]     half_delay_q, tick_q;

	logic [PB+GAIN_W-1:0]   p1_q;
	logic signed [PB:0]     dd_q;
	logic signed [SW-1:0]   p2_q;
	logic [SPEED_W-1:0]     ctl_q;
	logic [DEN_W-1:0]       den_q;
	logic [NUM_W-1:0]       rem_q, quo_q, numsh_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [OUT_W-1:0]       out_q;

	logic                   busy, val_neg;
	logic [MOVE_W-1:0]      val_abs;
	logic [31:0]            val_ext, pos_ext;
	logic [DB:0]            tick_inc;
	logic                   fire;
	logic signed [PB:0]     diff;
	logic [PB-1:0]          diff_abs;
	logic signed [SW-1:0]   sum_w, min_s, max_s;
	logic [NUM_W:0]         trial;
	logic                   trial_ok;
	logic [DB+31:0]         q_w, max_w;
	logic [MOVE_W-1:0]      sl_dec;

	assign busy     = (phase_q != PH_IDLE);
	assign val_neg  = val_q[MOVE_W-1];
	assign val_abs  = val_neg ? (~val_q + 1'b1) : val_q;
	assign val_ext  = 32'($signed(val_q));
	assign pos_ext  = 32'($signed(position_q));
	assign tick_inc = {1'b0, tick_q} + 1'b1;
	assign fire     = (tick_inc >= {1'b0, half_delay_q});
	assign diff     = $signed({goal_q[PB-1], goal_q}) - $signed({position_q[PB-1], position_q});
	assign diff_abs = diff[PB] ? PB'(-diff) : diff[PB-1:0];
	assign sum_w    = $signed({2'b00, p1_q}) + p2_q;
	assign min_s    = $signed({{(SW-SPEED_W){1'b0}}, CTL_MIN});
	assign max_s    = $signed({{(SW-SPEED_W){1'b0}}, CTL_MAX});
	assign trial    = {rem_q, numsh_q[NUM_W-1]};
	assign trial_ok = (trial >= {{(NUM_W+1-DEN_W){1'b0}}, den_q});
	assign q_w      = (DB+32)'(quo_q);
	assign max_w    = (DB+32)'({DB{1'b1}});
	assign sl_dec   = (steps_left_q != '0) ? steps_left_q - 1'b1 : steps_left_q;

	assign sts.go_plan   = (op_q == OP_ABS && !busy) ||
	                       (op_q == OP_TICK && busy && fire && phase_q == PH_LOW && pd_mode_q);
	assign sts.go_den    = (op_q == OP_REL) && !busy && (val_q != '0);
	assign sts.diff_zero = (diff == '0);
	assign sts.div_done  = (cnt_q == DIV_CNT_W'(NUM_W - 1));
	assign out_data      = out_q;

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q   <= '0;
			goal_q       <= '0;
			steps_left_q <= '0;
			pd_mode_q    <= 1'b0;
			phase_q      <= PH_IDLE;
			half_delay_q <= '0;
			tick_q       <= '0;
			prev_err_q   <= '0;
			direction_q  <= 1'b0;
		end else begin
			if (cmd.exec) begin
				if (op_q == OP_TICK && busy) begin
					if (!fire) begin
						tick_q <= tick_inc[DB-1:0];
					end else begin
						tick_q <= '0;
						if (phase_q == PH_HIGH) begin
							phase_q <= PH_LOW;
						end else begin
							position_q <= direction_q ? position_q - 1'b1 : position_q + 1'b1;
							if (!pd_mode_q) begin
								steps_left_q <= sl_dec;
								if (sl_dec != '0) begin
									phase_q <= PH_HIGH;
								end else begin
									phase_q   <= PH_IDLE;
									pd_mode_q <= 1'b0;
								end
							end
						end
					end
				end else if (op_q == OP_ABS && !busy) begin
					goal_q     <= val_ext[PB-1:0];
					prev_err_q <= '0;
				end else if (op_q == OP_REL && !busy) begin
					direction_q  <= val_neg || (val_q == '0);
					steps_left_q <= val_abs;
					if (val_q != '0) begin
						pd_mode_q <= 1'b0;
						phase_q   <= PH_HIGH;
						tick_q    <= '0;
					end
				end
			end
			if (cmd.plan_diff) begin
				tick_q <= '0;
				if (diff == '0) begin
					phase_q   <= PH_IDLE;
					pd_mode_q <= 1'b0;
				end else begin
					direction_q <= diff[PB];
					pd_mode_q   <= 1'b1;
					phase_q     <= PH_HIGH;
				end
			end
			if (cmd.sum)
				prev_err_q <= err_q;
			if (cmd.load_delay) begin
				if (den_q == '0 || q_w > max_w)
					half_delay_q <= {DB{1'b1}};
				else if (quo_q == '0)
					half_delay_q <= DB'(1);
				else
					half_delay_q <= q_w[DB-1:0];
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q  <= in_op;
			val_q <= in_val;
		end
		if (cmd.exec)
			ctl_q <= const_speed_q12;
		if (cmd.plan_diff)
			err_q <= diff_abs;
		if (cmd.mul1) begin
			p1_q <= kp_q12 * err_q;
			dd_q <= $signed({1'b0, err_q}) - $signed({1'b0, prev_err_q});
		end
		if (cmd.mul2)
			p2_q <= SW'($signed({1'b0, kd_q12}) * dd_q);
		if (cmd.sum) begin
			if (sum_w < min_s)
				ctl_q <= CTL_MIN;
			else if (sum_w > max_s)
				ctl_q <= CTL_MAX;
			else
				ctl_q <= sum_w[SPEED_W-1:0];
		end
		if (cmd.den) begin
			den_q   <= steps_per_rev * ctl_q;
			rem_q   <= '0;
			quo_q   <= '0;
			numsh_q <= DELAY_NUM;
			cnt_q   <= '0;
		end
		if (cmd.div_step) begin
			rem_q   <= trial_ok ? NUM_W'(trial - {{(NUM_W+1-DEN_W){1'b0}}, den_q})
			                    : trial[NUM_W-1:0];
			quo_q   <= {quo_q[NUM_W-2:0], trial_ok};
			numsh_q <= {numsh_q[NUM_W-2:0], 1'b0};
			cnt_q   <= cnt_q + 1'b1;
		end
		if (cmd.load_out)
			out_q <= {5'b0, busy, pos_ext[MOVE_W-1:0], direction_q, phase_q == PH_HIGH};
	end

`ifndef NO_ASSERTIONS
	a_idle_not_pd: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> !pd_mode_q)
		else $error("PD mode left set while idle");
`endif

endmodule

>>> rtl/core/stepper_pd_step_generator.sv
// Top level of the stepper PD step generator: APB registers, stream ports, core.
//
// Input stream (s_*): one transaction per command. s_tuser carries the operation
// (tick, start absolute PD move, start relative move), s_tdata the signed move value.
// Output stream (m_*): exactly one result transaction per input transaction, in order,
// showing step pin, direction pin, current position and busy flag after that command.
// Each transaction is worked through by a controller state machine driving a datapath.
// A tick or an ignored command goes from decode straight to the output state. A start,
// or a tick that ends a PD step, recomputes the half-step delay with a 32-step restoring
// divider (one quotient bit a cycle); a PD step also runs multiply, multiply and clamp
// stages first.
// s_tready is high only while no command is in work; one command is handled at a time.
// A finished result sits in the output register; if the receiver stalls, the next
// command is still accepted and worked, and it waits only to hand over its result.
// Reset clears position, move state and the output valid flag and loads the register
// defaults (200 steps/rev, 1.0 rev/s, kp 0.02, kd 0.7). Write registers only while idle.
module stepper_pd_step_generator #(
	parameter int POSITION_BITS = spsg_pkg::POSITION_BITS_DEF,
	parameter int DELAY_BITS    = spsg_pkg::DELAY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [23:0] move_value
	input  logic [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [0] step_out, [1] dir_out, [25:2] position_now, [26] busy_res
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import spsg_pkg::*;

	logic [SPR_W-1:0]   spr_q;
	logic [SPEED_W-1:0] speed_q;
	logic [GAIN_W-1:0]  kp_q, kd_q;
	logic               reg_wr;
	logic [1:0]         reg_idx;
	spsg_cmd_t          cmd;
	spsg_sts_t          sts;

	// register file: word addressed, always ready
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q   <= SPR_RST;
			speed_q <= SPEED_RST;
			kp_q    <= KP_RST;
			kd_q    <= KD_RST;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_SPR:   spr_q   <= pwdata[SPR_W-1:0];
				REG_SPEED: speed_q <= pwdata[SPEED_W-1:0];
				REG_KP:    kp_q    <= pwdata[GAIN_W-1:0];
				REG_KD:    kd_q    <= pwdata[GAIN_W-1:0];
				default:   spr_q   <= spr_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SPR:   prdata = {17'b0, spr_q};
			REG_SPEED: prdata = {16'b0, speed_q};
			REG_KP:    prdata = {16'b0, kp_q};
			REG_KD:    prdata = {16'b0, kd_q};
			default:   prdata = '0;
		endcase
	end

	spsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	spsg_dp #(
		.POSITION_BITS (POSITION_BITS),
		.DELAY_BITS    (DELAY_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_op           (s_tuser),
		.in_val          (s_tdata),
		.steps_per_rev   (spr_q),
		.const_speed_q12 (speed_q),
		.kp_q12          (kp_q),
		.kd_q12          (kd_q),
		.out_data        (m_tdata)
	);

endmodule
